>>> rtl/espa_pkg.sv
// Shared types and constants for the effect slot pool.
package espa_pkg;

    localparam int REQ_W       = 2;
    localparam int POS_W       = 32;
    localparam int PARAM_IN_W  = 16;
    localparam int COLOR_W     = 32;
    localparam int DT_W        = 10;
    localparam int SLOT_IDX_W  = 4;
    localparam int EXPIRED_W   = 5;
    localparam int MASK_W      = 16;

    localparam int AGE_W       = 12;
    localparam int DUR_W       = 11;
    localparam int SCALE_W     = 10;
    localparam int INTEN_W     = 10;

    localparam logic [REQ_W-1:0] REQ_SPAWN = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [AGE_W-1:0] AGE_MAX = 12'd4095;

    localparam logic [DUR_W-1:0] SCALE_ONE    = 11'd256;
    localparam logic [DUR_W-1:0] SCALE_MIN    = 11'd90;
    localparam logic [DUR_W-1:0] SCALE_MAX    = 11'd896;
    localparam logic [DUR_W-1:0] INTEN_ONE    = 11'd256;
    localparam logic [DUR_W-1:0] INTEN_MIN    = 11'd51;
    localparam logic [DUR_W-1:0] INTEN_MAX    = 11'd640;
    localparam logic [DUR_W-1:0] DUR_FALLBACK = 11'd340;
    localparam logic [DUR_W-1:0] DUR_MIN      = 11'd120;
    localparam logic [DUR_W-1:0] DUR_MAX      = 11'd1200;

    localparam logic [SCALE_W-1:0] DEF_SCALE = 10'd269;
    localparam logic [DUR_W-1:0]   DEF_DUR   = 11'd700;
    localparam logic [INTEN_W-1:0] DEF_INTEN = 10'd294;
    localparam logic [COLOR_W-1:0] DEF_COLOR = 32'hFFEA00FF;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic out_load;
    } espa_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } espa_status_t;

endpackage

>>> rtl/espa_ctrl.sv
// Sequencer for the effect slot pool: accept, slot scan, commit, result.
module espa_ctrl
    import espa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  espa_status_t status,
    output espa_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

>>> rtl/espa_dp.sv
// Datapath for the effect slot pool: request latch, slot state, scan unit, result register.
module espa_dp
    import espa_pkg::*;
#(
    parameter int SLOT_COUNT = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  espa_cmd_t                    cmd,
    output espa_status_t                 status,
    input  logic [REQ_W-1:0]             req_type,
    input  logic signed [POS_W-1:0]      pos_x,
    input  logic signed [POS_W-1:0]      pos_y,
    input  logic                         use_defaults,
    input  logic signed [PARAM_IN_W-1:0] scale_in,
    input  logic signed [PARAM_IN_W-1:0] duration_in,
    input  logic signed [PARAM_IN_W-1:0] intensity_in,
    input  logic [COLOR_W-1:0]           color_in,
    input  logic [DT_W-1:0]              dt_ms,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [SLOT_IDX_W-1:0]        slot_index,
    output logic                         evicted,
    output logic [EXPIRED_W-1:0]         expired_count,
    output logic [MASK_W-1:0]            active_mask
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [SCALE_W-1:0] scale;
        logic [INTEN_W-1:0] intensity;
        logic [COLOR_W-1:0] color;
    } payload_t;

    function automatic logic [DUR_W-1:0] clean_val(
        input logic signed [PARAM_IN_W-1:0] v,
        input logic [DUR_W-1:0]             fb,
        input logic [DUR_W-1:0]             lo,
        input logic [DUR_W-1:0]             hi
    );
        logic [DUR_W-1:0] r;
        if (v <= 16'sd0)
        begin
            r = fb;
        end
        else if (v < signed'({5'b0, lo}))
        begin
            r = lo;
        end
        else if (v > signed'({5'b0, hi}))
        begin
            r = hi;
        end
        else
        begin
            r = v[DUR_W-1:0];
        end
        return r;
    endfunction

    // latched transaction
    logic [REQ_W-1:0]  req_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [DUR_W-1:0]  dur_reg;
    payload_t          pay_reg;

    // slot state
    logic [SLOT_COUNT-1:0] active_reg;
    logic [AGE_W-1:0]      age_mem [SLOT_COUNT];
    logic [DUR_W-1:0]      dur_mem [SLOT_COUNT];
    payload_t              pay_mem [SLOT_COUNT];

    // scan state
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  found_reg;
    logic [IDX_W-1:0]      found_idx_reg;
    logic                  seen_reg;
    logic [IDX_W-1:0]      oldest_idx_reg;
    logic [AGE_W-1:0]      max_age_reg;
    logic [EXPIRED_W-1:0]  exp_reg;
    logic [SLOT_IDX_W-1:0] res_idx_reg;
    logic                  res_ev_reg;

    // result register
    logic                  out_valid_reg;
    logic [SLOT_IDX_W-1:0] slot_index_reg;
    logic                  evicted_reg;
    logic [EXPIRED_W-1:0]  expired_reg;
    logic [MASK_W-1:0]     mask_reg;

    logic                  cur_active;
    logic [AGE_W-1:0]      cur_age_reg;
    logic [DUR_W-1:0]      cur_dur_reg;
    logic [AGE_W:0]        age_sum;
    logic [AGE_W-1:0]      age_sat;
    logic [IDX_W-1:0]      tgt_idx;
    logic [MASK_W-1:0]     mask_now;
    logic signed [PARAM_IN_W-1:0] sc_sel;
    logic signed [PARAM_IN_W-1:0] du_sel;
    logic signed [PARAM_IN_W-1:0] it_sel;
    logic [COLOR_W-1:0]    col_sel;

    assign cur_active = active_reg[idx_reg];
    assign age_sum    = {1'b0, cur_age_reg} + (AGE_W + 1)'(dt_reg);
    assign age_sat    = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
    assign tgt_idx    = found_reg ? found_idx_reg : oldest_idx_reg;

    always_comb
    begin
        if (use_defaults)
        begin
            sc_sel  = PARAM_IN_W'(signed'({1'b0, DEF_SCALE}));
            du_sel  = PARAM_IN_W'(signed'({1'b0, DEF_DUR}));
            it_sel  = PARAM_IN_W'(signed'({1'b0, DEF_INTEN}));
            col_sel = DEF_COLOR;
        end
        else
        begin
            sc_sel  = scale_in;
            du_sel  = duration_in;
            it_sel  = intensity_in;
            col_sel = (color_in[7:0] == 8'd0) ? DEF_COLOR : color_in;
        end
    end

    always_comb
    begin
        mask_now = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            mask_now[i] = active_reg[i];
        end
    end

    always_comb
    begin
        status.out_free  = !out_valid_reg || !out_stall;
        status.scan_done = (idx_reg == LAST_IDX);
        if (req_reg == REQ_SPAWN)
        begin
            if (!cur_active)
            begin
                status.scan_done = 1'b1;
            end
        end
        else if (req_reg != REQ_TICK)
        begin
            status.scan_done = 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.scan && !status.scan_done)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_age_reg <= age_mem[idx_next];
        cur_dur_reg <= dur_mem[idx_next];
        if (cmd.load)
        begin
            req_reg           <= req_type;
            dt_reg            <= dt_ms;
            dur_reg           <= clean_val(du_sel, DUR_FALLBACK, DUR_MIN, DUR_MAX);
            pay_reg.pos_x     <= pos_x;
            pay_reg.pos_y     <= pos_y;
            pay_reg.scale     <= SCALE_W'(clean_val(sc_sel, SCALE_ONE, SCALE_MIN, SCALE_MAX));
            pay_reg.intensity <= INTEN_W'(clean_val(it_sel, INTEN_ONE, INTEN_MIN, INTEN_MAX));
            pay_reg.color     <= col_sel;
        end
        if (cmd.scan && req_reg == REQ_TICK && cur_active)
        begin
            age_mem[idx_reg] <= age_sat;
        end
        if (cmd.commit && req_reg == REQ_SPAWN)
        begin
            age_mem[tgt_idx] <= '0;
            dur_mem[tgt_idx] <= dur_reg;
            pay_mem[tgt_idx] <= pay_reg;
        end
        if (cmd.out_load)
        begin
            slot_index_reg <= res_idx_reg;
            evicted_reg    <= res_ev_reg;
            expired_reg    <= exp_reg;
            mask_reg       <= mask_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            found_idx_reg  <= '0;
            seen_reg       <= 1'b0;
            oldest_idx_reg <= '0;
            max_age_reg    <= '0;
            exp_reg        <= '0;
            res_idx_reg    <= '0;
            res_ev_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                found_reg   <= 1'b0;
                seen_reg    <= 1'b0;
                exp_reg     <= '0;
                res_idx_reg <= '0;
                res_ev_reg  <= 1'b0;
            end
            if (cmd.scan)
            begin
                if (req_reg == REQ_SPAWN)
                begin
                    if (!cur_active)
                    begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= idx_reg;
                    end
                    else if (!seen_reg || cur_age_reg > max_age_reg)
                    begin
                        seen_reg       <= 1'b1;
                        oldest_idx_reg <= idx_reg;
                        max_age_reg    <= cur_age_reg;
                    end
                end
                else if (req_reg == REQ_TICK && cur_active)
                begin
                    if (age_sat >= {1'b0, cur_dur_reg})
                    begin
                        active_reg[idx_reg] <= 1'b0;
                        exp_reg             <= exp_reg + EXPIRED_W'(1);
                    end
                end
            end
            if (cmd.commit)
            begin
                if (req_reg == REQ_SPAWN)
                begin
                    active_reg[tgt_idx] <= 1'b1;
                    res_idx_reg         <= SLOT_IDX_W'(tgt_idx);
                    res_ev_reg          <= !found_reg;
                end
                else if (req_reg == REQ_CLEAR)
                begin
                    active_reg <= '0;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign slot_index    = slot_index_reg;
    assign evicted       = evicted_reg;
    assign expired_count = expired_reg;
    assign active_mask   = mask_reg;

endmodule

>>> rtl/effect_slot_pool_with_aging_core.sv
// Top level of the effect slot pool with oldest-slot replacement.
//
//  channel | signals                                    | accepted when
//  --------+--------------------------------------------+----------------------
//  input   | in_valid, in_stall, request fields         | in_valid && !in_stall
//  output  | out_valid, out_stall, result fields        | out_valid && !out_stall
//
// A transaction is latched, then the slots are scanned
// (one slot per cycle; a spawn stops at the first free slot, a clear at once),
// then it is committed and its result is loaded into the result register.
// Reset (rst_n, asynchronous) empties the pool; no clearing pass is needed.
// A pending result in the output register does not block the next request;
// only the result load waits while out_stall holds the previous one.
module effect_slot_pool_with_aging_core
    import espa_pkg::*;
#(
    parameter int SLOT_COUNT = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [REQ_W-1:0]             req_type,
    input  logic signed [POS_W-1:0]      pos_x,
    input  logic signed [POS_W-1:0]      pos_y,
    input  logic                         use_defaults,
    input  logic signed [PARAM_IN_W-1:0] scale_in,
    input  logic signed [PARAM_IN_W-1:0] duration_in,
    input  logic signed [PARAM_IN_W-1:0] intensity_in,
    input  logic [COLOR_W-1:0]           color_in,
    input  logic [DT_W-1:0]              dt_ms,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [SLOT_IDX_W-1:0]        slot_index,
    output logic                         evicted,
    output logic [EXPIRED_W-1:0]         expired_count,
    output logic [MASK_W-1:0]            active_mask
);

    espa_cmd_t    cmd;
    espa_status_t status;

    espa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    espa_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req_type),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .use_defaults  (use_defaults),
        .scale_in      (scale_in),
        .duration_in   (duration_in),
        .intensity_in  (intensity_in),
        .color_in      (color_in),
        .dt_ms         (dt_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_index    (slot_index),
        .evicted       (evicted),
        .expired_count (expired_count),
        .active_mask   (active_mask)
    );

endmodule

>>> tb/effect_slot_pool_with_aging_core_test.sv
// Testbench for the effect slot pool: directed corner requests, then random spawn/tick/clear/unused traffic.
module effect_slot_pool_with_aging_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import espa_pkg::*;

    localparam int SLOTS        = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 650;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY, STALL_PERIODIC} stall_mode_t;

    typedef struct packed {
        logic [REQ_W-1:0]      kind;
        logic [POS_W-1:0]      px;
        logic [POS_W-1:0]      py;
        logic                  dflt;
        logic [PARAM_IN_W-1:0] sc;
        logic [PARAM_IN_W-1:0] du;
        logic [PARAM_IN_W-1:0] it;
        logic [COLOR_W-1:0]    col;
        logic [DT_W-1:0]       dt;
    } pool_req_t;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot;
        logic                  evict;
        logic [EXPIRED_W-1:0]  expired;
        logic [MASK_W-1:0]     mask;
    } pool_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [REQ_W-1:0]             req_type;
    logic signed [POS_W-1:0]      pos_x;
    logic signed [POS_W-1:0]      pos_y;
    logic                         use_defaults;
    logic signed [PARAM_IN_W-1:0] scale_in;
    logic signed [PARAM_IN_W-1:0] duration_in;
    logic signed [PARAM_IN_W-1:0] intensity_in;
    logic [COLOR_W-1:0]           color_in;
    logic [DT_W-1:0]              dt_ms;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [SLOT_IDX_W-1:0]        slot_index;
    logic                         evicted;
    logic [EXPIRED_W-1:0]         expired_count;
    logic [MASK_W-1:0]            active_mask;

    // predicted pool contents
    logic                 pool_active [SLOTS];
    logic [AGE_W-1:0]     pool_age    [SLOTS];
    logic [DUR_W-1:0]     pool_dur    [SLOTS];
    logic [SCALE_W-1:0]   pool_scale  [SLOTS];
    logic [INTEN_W-1:0]   pool_inten  [SLOTS];
    logic [POS_W-1:0]     pool_px     [SLOTS];
    logic [POS_W-1:0]     pool_py     [SLOTS];
    logic [COLOR_W-1:0]   pool_color  [SLOTS];

    pool_result_t pending_results[$];
    pool_result_t oldest_expected;

    stall_mode_t stall_mode = STALL_NONE;
    int  stall_left  = 0;
    int  free_left   = 0;
    int  stall_phase = 0;
    bit  gaps_on     = 1'b1;
    int  burst_left  = 0;

    int cycle_count   = 0;
    int error_count   = 0;
    int checked_count = 0;
    int sent_count    = 0;
    int spawn_count   = 0;
    int tick_count    = 0;
    int evict_count   = 0;
    int expire_total  = 0;

    effect_slot_pool_with_aging_core #(.SLOT_COUNT(SLOTS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .use_defaults  (use_defaults),
        .scale_in      (scale_in),
        .duration_in   (duration_in),
        .intensity_in  (intensity_in),
        .color_in      (color_in),
        .dt_ms         (dt_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_index    (slot_index),
        .evicted       (evicted),
        .expired_count (expired_count),
        .active_mask   (active_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clean_param(int v, int fallback, int lo, int hi);
        int r;
        r = (v <= 0) ? fallback : v;
        if (r < lo)
            r = lo;
        if (r > hi)
            r = hi;
        return r;
    endfunction

    function automatic pool_result_t predict_pool_step(pool_req_t r);
        pool_result_t res;
        int found;
        int oldest;
        int max_age;
        int a;
        int sc;
        int du;
        int it;
        int freed;
        logic [COLOR_W-1:0] col;
        res = '0;
        freed = 0;
        case (r.kind)
            REQ_SPAWN:
            begin
                if (r.dflt)
                begin
                    sc  = int'(DEF_SCALE);
                    du  = int'(DEF_DUR);
                    it  = int'(DEF_INTEN);
                    col = DEF_COLOR;
                end
                else
                begin
                    sc  = int'($signed(r.sc));
                    du  = int'($signed(r.du));
                    it  = int'($signed(r.it));
                    col = r.col;
                end
                if (col[7:0] == 8'h00)
                    col = DEF_COLOR;
                found = -1;
                oldest = 0;
                max_age = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (found < 0)
                    begin
                        if (!pool_active[i])
                            found = i;
                        else if (int'(pool_age[i]) > max_age)
                        begin
                            max_age = int'(pool_age[i]);
                            oldest = i;
                        end
                    end
                end
                if (found < 0)
                begin
                    found = oldest;
                    res.evict = 1'b1;
                end
                pool_active[found] = 1'b1;
                pool_age[found]    = '0;
                pool_scale[found]  = SCALE_W'(clean_param(sc, int'(SCALE_ONE),
                                                          int'(SCALE_MIN), int'(SCALE_MAX)));
                pool_dur[found]    = DUR_W'(clean_param(du, int'(DUR_FALLBACK),
                                                        int'(DUR_MIN), int'(DUR_MAX)));
                pool_inten[found]  = INTEN_W'(clean_param(it, int'(INTEN_ONE),
                                                          int'(INTEN_MIN), int'(INTEN_MAX)));
                pool_px[found]     = r.px;
                pool_py[found]     = r.py;
                pool_color[found]  = col;
                res.slot = SLOT_IDX_W'(found);
            end
            REQ_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (pool_active[i])
                    begin
                        a = int'(pool_age[i]) + int'(r.dt);
                        if (a > int'(AGE_MAX))
                            a = int'(AGE_MAX);
                        pool_age[i] = a[AGE_W-1:0];
                        if (a >= int'(pool_dur[i]))
                        begin
                            pool_active[i] = 1'b0;
                            freed++;
                        end
                    end
                end
                res.expired = EXPIRED_W'(freed);
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    pool_active[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < SLOTS; i++)
            res.mask[i] = pool_active[i];
        return res;
    endfunction

    // unused fields carry random noise
    function automatic pool_req_t base_request(logic [REQ_W-1:0] kind);
        pool_req_t r;
        r.kind = kind;
        r.px   = $urandom;
        r.py   = $urandom;
        r.dflt = 1'b0;
        r.sc   = PARAM_IN_W'($urandom);
        r.du   = PARAM_IN_W'($urandom);
        r.it   = PARAM_IN_W'($urandom);
        r.col  = $urandom;
        r.dt   = DT_W'($urandom_range(0, 1023));
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
                 checked_count);
        error_count++;
    endtask

    // entered and left at a falling edge with nothing yet driven in that step
    task automatic send_request(pool_req_t r);
        int gap;
        pool_result_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        req_type     <= r.kind;
        pos_x        <= r.px;
        pos_y        <= r.py;
        use_defaults <= r.dflt;
        scale_in     <= r.sc;
        duration_in  <= r.du;
        intensity_in <= r.it;
        color_in     <= r.col;
        dt_ms        <= r.dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = predict_pool_step(r);
        pending_results.push_back(res);
        sent_count++;
        if (r.kind == REQ_SPAWN)
            spawn_count++;
        if (r.kind == REQ_TICK)
            tick_count++;
        evict_count  += int'(res.evict);
        expire_total += int'(res.expired);
        @(negedge clk);
    endtask

    task automatic wait_for_results;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_idle_after_reset;
        pool_req_t r;
        r = base_request(REQ_UNUSED);
        send_request(r);
        r = base_request(REQ_TICK);
        r.dt = '0;
        send_request(r);
        wait_for_results;
    endtask

    // parameter corners while filling, then replacement of the oldest slot
    task automatic test_fill_and_evict;
        pool_req_t r;
        logic [PARAM_IN_W-1:0] corner [16] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001,
                                               16'd119, 16'd120, 16'd1200, 16'd1201,
                                               16'd89, 16'd90, 16'd896, 16'd897,
                                               16'd51, 16'd640, 16'd641, 16'h7FFF};
        for (int i = 0; i < SLOTS; i++)
        begin
            r = base_request(REQ_SPAWN);
            r.sc   = corner[i];
            r.du   = corner[(i + 5) % 16];
            r.it   = corner[(i + 10) % 16];
            r.dflt = (i == 7);
            if (i == 0)
            begin
                r.px = 32'h80000000;
                r.py = 32'h7FFFFFFF;
            end
            if (i == 1)
            begin
                r.px = 32'h7FFFFFFF;
                r.py = 32'h80000000;
            end
            if (i == 2)
            begin
                r.px  = 32'h00000000;
                r.py  = 32'hFFFFFFFF;
                r.col = 32'h00000000;
            end
            if (i == 3)
                r.col = 32'hFFFFFF00;
            if (i == 4)
                r.col = 32'hFFFFFFFF;
            send_request(r);
        end
        r = base_request(REQ_TICK);
        r.dt = 10'd30;
        send_request(r);
        // all ages tie: slot 0 goes first, then slot 1 as the oldest
        send_request(base_request(REQ_SPAWN));
        send_request(base_request(REQ_SPAWN));
        wait_for_results;
    endtask

    task automatic test_tick_expiry;
        pool_req_t r;
        r = base_request(REQ_TICK);
        r.dt = 10'd1023;
        send_request(r);
        send_request(r);
        wait_for_results;
    endtask

    task automatic test_clear_and_unused;
        pool_req_t r;
        r = base_request(REQ_SPAWN);
        r.dflt = 1'b1;
        send_request(r);
        send_request(base_request(REQ_CLEAR));
        send_request(base_request(REQ_UNUSED));
        wait_for_results;
    endtask

    task automatic test_random_traffic(int count);
        pool_req_t r;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if (n % 80 == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (n % 150 == 149)
                wait_for_results;
            pick = $urandom_range(0, 99);
            if (pick < 56)
                r = base_request(REQ_SPAWN);
            else if (pick < 95)
                r = base_request(REQ_TICK);
            else if (pick < 97)
                r = base_request(REQ_CLEAR);
            else
                r = base_request(REQ_UNUSED);
            if (r.kind == REQ_SPAWN)
            begin
                r.dflt = ($urandom_range(0, 6) == 0);
                case ($urandom_range(0, 5))
                    0, 1: r.du = PARAM_IN_W'($urandom_range(120, 1200));
                    2:    r.du = PARAM_IN_W'(-$urandom_range(0, 32768));
                    3:    r.du = PARAM_IN_W'($urandom_range(0, 130));
                    4:    r.du = PARAM_IN_W'($urandom_range(1150, 1300));
                    default: r.du = PARAM_IN_W'($urandom);
                endcase
                if ($urandom_range(0, 1))
                    r.sc = PARAM_IN_W'($urandom_range(0, 1000));
                if ($urandom_range(0, 1))
                    r.it = PARAM_IN_W'($urandom_range(0, 700));
                if ($urandom_range(0, 7) == 0)
                    r.col[7:0] = 8'h00;
            end
            else if (r.kind == REQ_TICK)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    r.dt = DT_W'($urandom_range(0, 60));
                else if (pick < 17)
                    r.dt = DT_W'($urandom_range(61, 400));
            end
            send_request(r);
        end
    endtask

    always @(negedge clk)
    begin
        stall_phase++;
        case (stall_mode)
            STALL_RANDOM:
                out_stall <= ($urandom_range(0, 2) == 0);
            STALL_BURSTY:
            begin
                if (stall_left > 0)
                begin
                    out_stall <= 1'b1;
                    stall_left--;
                end
                else if (free_left > 0)
                begin
                    out_stall <= 1'b0;
                    free_left--;
                end
                else
                begin
                    out_stall <= 1'b0;
                    stall_left = $urandom_range(1, 24);
                    free_left = $urandom_range(1, 10);
                end
            end
            STALL_PERIODIC:
                out_stall <= ((stall_phase % 7) < 3);
            default:
                out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no transaction pending", 0, 0);
            else
            begin
                oldest_expected = pending_results.pop_front();
                if (slot_index !== oldest_expected.slot)
                    report_mismatch("slot_index", int'(slot_index),
                                    int'(oldest_expected.slot));
                if (evicted !== oldest_expected.evict)
                    report_mismatch("evicted", int'(evicted), int'(oldest_expected.evict));
                if (expired_count !== oldest_expected.expired)
                    report_mismatch("expired_count", int'(expired_count),
                                    int'(oldest_expected.expired));
                if (active_mask !== oldest_expected.mask)
                    report_mismatch("active_mask", int'(active_mask),
                                    int'(oldest_expected.mask));
            end
            checked_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = '0;
        pos_x        = '0;
        pos_y        = '0;
        use_defaults = 1'b0;
        scale_in     = '0;
        duration_in  = '0;
        intensity_in = '0;
        color_in     = '0;
        dt_ms        = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            pool_active[i] = 1'b0;
            pool_age[i]    = '0;
            pool_dur[i]    = '0;
            pool_scale[i]  = '0;
            pool_inten[i]  = '0;
            pool_px[i]     = '0;
            pool_py[i]     = '0;
            pool_color[i]  = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        stall_mode = STALL_NONE;
        test_idle_after_reset;
        stall_mode = STALL_RANDOM;
        test_fill_and_evict;
        stall_mode = STALL_BURSTY;
        test_tick_expiry;
        stall_mode = STALL_PERIODIC;
        test_clear_and_unused;
        test_random_traffic(RANDOM_ITEMS);

        wait_for_results;
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d transactions: %0d spawns with %0d replacements,",
                 sent_count, spawn_count, evict_count);
        $display("  %0d ticks freeing %0d slots", tick_count, expire_total);
        $display("Checked %0d results, %0d mismatches", checked_count, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/espa_pkg.sv
rtl/espa_ctrl.sv
rtl/espa_dp.sv
rtl/effect_slot_pool_with_aging_core.sv
tb/effect_slot_pool_with_aging_core_test.sv
